@@ hw/rtl/cccpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cccpg_pkg: shared types and helpers for the clipped circle point generator
// Holds the job record passed from front to back, the opcode and register
// codes, and the symmetric point and screen clip functions.
// ----------------------------------------------------------------------------
package cccpg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int RADIUS_BITS   = 10;
    localparam int MAX_RADIUS    = 1023;
    localparam int STEP_BITS     = 11;
    localparam int ACC_BITS      = 14;
    localparam int PT_BITS       = COORD_BITS + 2;
    localparam int INV_SQRT2_Q16 = 46341;
    localparam int Q_BITS        = 16;
    localparam int PROD_BITS     = RADIUS_BITS + Q_BITS;
    localparam int NUM_PTS       = 16;
    localparam int PT_IDX_BITS   = $clog2(NUM_PTS);
    localparam int DATA_BITS     = 32;
    localparam int ADDR_BITS     = 3;

    // Depth must stay a power of two: pointers wrap on overflow
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACC_BITS-1:0]   DEC_BASE   = ACC_BITS'(3);
    localparam logic [ACC_BITS-1:0]   HINC_INIT  = ACC_BITS'(6);
    localparam logic [ACC_BITS-1:0]   DINC_BASE  = ACC_BITS'(10);
    localparam logic [ACC_BITS-1:0]   INC_STEP   = ACC_BITS'(4);
    localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(480);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0]       org_x;
        logic [COORD_BITS-1:0]       org_y;
        logic [STEP_BITS-1:0]        x;
        logic signed [STEP_BITS-1:0] y;
        logic [NUM_PTS-1:0]          mask;
        logic                        done;
    } t_job;

    typedef struct packed {
        logic signed [PT_BITS-1:0] px;
        logic signed [PT_BITS-1:0] py;
    } t_point;

    // sym[2] swaps the offsets, sym[1] negates the column, sym[0] the row
    function automatic t_point point_at(input logic [COORD_BITS-1:0] ox,
                                        input logic [COORD_BITS-1:0] oy,
                                        input logic [STEP_BITS-1:0] x,
                                        input logic signed [STEP_BITS-1:0] y,
                                        input logic [2:0] sym);
        logic signed [PT_BITS-1:0] xs;
        logic signed [PT_BITS-1:0] ys;
        logic signed [PT_BITS-1:0] a;
        logic signed [PT_BITS-1:0] b;
        t_point p;
        xs = {{(PT_BITS - STEP_BITS){1'b0}}, x};
        ys = {{(PT_BITS - STEP_BITS){y[STEP_BITS-1]}}, y};
        a = sym[2] ? ys : xs;
        b = sym[2] ? xs : ys;
        p.px = $signed({2'b00, ox}) + (sym[1] ? -a : a);
        p.py = $signed({2'b00, oy}) + (sym[0] ? -b : b);
        return p;
    endfunction

    function automatic logic on_screen(input t_point p,
                                       input logic [COORD_BITS-1:0] w,
                                       input logic [COORD_BITS-1:0] h);
        return (p.px > $signed(PT_BITS'(0))) && (p.px <= $signed({2'b00, w})) &&
               (p.py > $signed(PT_BITS'(0))) && (p.py <= $signed({2'b00, h}));
    endfunction

endpackage

@@ hw/rtl/cccpg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cccpg_front: circle state and step classifier
// Loads a circle on start, advances the midpoint recurrence on each step and
// hands the back end a job with the clip mask of all sixteen candidates.
// ----------------------------------------------------------------------------
module cccpg_front (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    input  logic                                       i_queue_full,
    input  logic                                       i_opcode,
    input  logic [cccpg_pkg::COORD_BITS-1:0]           i_center_x,
    input  logic [cccpg_pkg::COORD_BITS-1:0]           i_center_y,
    input  logic [cccpg_pkg::RADIUS_BITS-1:0]          i_circle_radius,
    input  logic [cccpg_pkg::COORD_BITS-1:0]           i_width,
    input  logic [cccpg_pkg::COORD_BITS-1:0]           i_height,
    output logic                                       o_in_ready,
    output logic                                       o_push,
    output cccpg_pkg::t_job                            o_job
);

    logic [cccpg_pkg::COORD_BITS-1:0]         r_org_x, n_org_x;
    logic [cccpg_pkg::COORD_BITS-1:0]         r_org_y, n_org_y;
    logic [cccpg_pkg::STEP_BITS-1:0]          r_x, n_x;
    logic signed [cccpg_pkg::STEP_BITS-1:0]   r_y, n_y;
    logic signed [cccpg_pkg::ACC_BITS-1:0]    r_dec, n_dec;
    logic signed [cccpg_pkg::ACC_BITS-1:0]    r_hinc, n_hinc;
    logic signed [cccpg_pkg::ACC_BITS-1:0]    r_dinc, n_dinc;
    logic [cccpg_pkg::STEP_BITS-1:0]          r_limit, n_limit;
    logic                                     r_active, n_active;

    logic                                     accept;
    logic                                     is_step;
    logic                                     diag;
    logic [cccpg_pkg::RADIUS_BITS-1:0]        rad;
    logic [cccpg_pkg::PROD_BITS-1:0]          prod;
    logic signed [cccpg_pkg::STEP_BITS-1:0]   y_m1;
    logic signed [cccpg_pkg::ACC_BITS-1:0]    dinc_d;
    logic [cccpg_pkg::STEP_BITS-1:0]          x_p1;
    logic [cccpg_pkg::NUM_PTS-1:0]            mask;

    assign accept  = i_in_valid && !i_queue_full;
    assign is_step = (i_opcode == cccpg_pkg::OP_STEP);
    assign o_in_ready = !i_queue_full;

    assign rad  = (i_circle_radius > cccpg_pkg::RADIUS_BITS'(cccpg_pkg::MAX_RADIUS)) ?
                  cccpg_pkg::RADIUS_BITS'(cccpg_pkg::MAX_RADIUS) : i_circle_radius;
    assign prod = cccpg_pkg::PROD_BITS'(rad) *
                  cccpg_pkg::PROD_BITS'(cccpg_pkg::INV_SQRT2_Q16);

    assign diag   = !r_dec[cccpg_pkg::ACC_BITS-1];
    assign y_m1   = r_y - cccpg_pkg::STEP_BITS'(1);
    assign dinc_d = r_dinc + cccpg_pkg::INC_STEP;
    assign x_p1   = r_x + cccpg_pkg::STEP_BITS'(1);

    always_comb begin
        for (int i = 0; i < cccpg_pkg::NUM_PTS / 2; i++) begin
            mask[i] = cccpg_pkg::on_screen(
                cccpg_pkg::point_at(r_org_x, r_org_y, r_x, r_y, 3'(i)), i_width, i_height);
            mask[i + cccpg_pkg::NUM_PTS / 2] = diag && cccpg_pkg::on_screen(
                cccpg_pkg::point_at(r_org_x, r_org_y, r_x, y_m1, 3'(i)), i_width, i_height);
        end
    end

    always_comb begin
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_hinc   = r_hinc;
        n_dinc   = r_dinc;
        n_limit  = r_limit;
        n_active = r_active;
        if (accept && !is_step) begin
            n_org_x  = i_center_x;
            n_org_y  = i_center_y;
            n_x      = '0;
            n_y      = cccpg_pkg::STEP_BITS'(rad);
            n_dec    = cccpg_pkg::DEC_BASE - cccpg_pkg::ACC_BITS'({rad, 1'b0});
            n_hinc   = cccpg_pkg::HINC_INIT;
            n_dinc   = cccpg_pkg::DINC_BASE - cccpg_pkg::ACC_BITS'({rad, 2'b00});
            n_limit  = cccpg_pkg::STEP_BITS'(prod[cccpg_pkg::PROD_BITS-1:cccpg_pkg::Q_BITS])
                       + cccpg_pkg::STEP_BITS'(1);
            n_active = 1'b1;
        end else if (accept && r_active) begin
            if (diag) begin
                n_y    = y_m1;
                n_dec  = r_dec + dinc_d;
                n_dinc = dinc_d + cccpg_pkg::INC_STEP;
            end else begin
                n_dec  = r_dec + r_hinc;
                n_dinc = dinc_d;
            end
            n_x      = x_p1;
            n_hinc   = r_hinc + cccpg_pkg::INC_STEP;
            n_active = !(x_p1 > r_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_hinc   <= cccpg_pkg::HINC_INIT;
            r_dinc   <= '0;
            r_limit  <= '0;
            r_active <= 1'b0;
        end else begin
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_hinc   <= n_hinc;
            r_dinc   <= n_dinc;
            r_limit  <= n_limit;
            r_active <= n_active;
        end
    end

    // With no circle in progress the job carries an empty mask and done set
    assign o_push     = accept && is_step;
    assign o_job.org_x = r_org_x;
    assign o_job.org_y = r_org_y;
    assign o_job.x     = r_x;
    assign o_job.y     = r_y;
    assign o_job.mask  = r_active ? mask : '0;
    assign o_job.done  = r_active ? (x_p1 > r_limit) : 1'b1;

endmodule

@@ hw/rtl/cccpg_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cccpg_queue: short job queue between front and back
// Holds classified step jobs so the front keeps taking items while the back
// drains points.
// ----------------------------------------------------------------------------
module cccpg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cccpg_pkg::t_job i_job,
    input  logic            i_pop,
    output cccpg_pkg::t_job o_head,
    output logic            o_head_valid,
    output logic            o_full
);

    cccpg_pkg::t_job                         r_mem [cccpg_pkg::QUEUE_DEPTH];
    logic [cccpg_pkg::QUEUE_PTR_BITS-1:0]    r_wr;
    logic [cccpg_pkg::QUEUE_PTR_BITS-1:0]    r_rd;
    logic [cccpg_pkg::QUEUE_CNT_BITS-1:0]    r_count;

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == cccpg_pkg::QUEUE_CNT_BITS'(cccpg_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + cccpg_pkg::QUEUE_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + cccpg_pkg::QUEUE_PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + cccpg_pkg::QUEUE_CNT_BITS'(1);
                2'b01:   r_count <= r_count - cccpg_pkg::QUEUE_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/cccpg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cccpg_back: point emitter
// Walks the head job's clip mask, lowest candidate first, and sends one point
// per cycle unless stalled, or one empty marker; flags the last of each step.
// ----------------------------------------------------------------------------
module cccpg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cccpg_pkg::t_job                      i_head,
    input  logic                                 i_head_valid,
    input  logic                                 i_ready,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [cccpg_pkg::COORD_BITS-1:0]     o_pixel_x,
    output logic [cccpg_pkg::COORD_BITS-1:0]     o_pixel_y,
    output logic                                 o_pixel_valid,
    output logic                                 o_last_of_step,
    output logic                                 o_circle_done
);

    logic                                    r_first;
    logic [cccpg_pkg::NUM_PTS-1:0]           r_rem;
    logic                                    r_ovalid;
    logic [cccpg_pkg::COORD_BITS-1:0]        r_px;
    logic [cccpg_pkg::COORD_BITS-1:0]        r_py;
    logic                                    r_pvalid;
    logic                                    r_last;
    logic                                    r_done;

    logic [cccpg_pkg::NUM_PTS-1:0]           eff;
    logic [cccpg_pkg::NUM_PTS-1:0]           pick;
    logic [cccpg_pkg::NUM_PTS-1:0]           rem_n;
    logic [cccpg_pkg::PT_IDX_BITS-1:0]       idx;
    logic                                    has_pt;
    logic                                    last;
    logic                                    load;
    logic signed [cccpg_pkg::STEP_BITS-1:0]  row_y;
    cccpg_pkg::t_point                       pt;

    assign eff    = r_first ? i_head.mask : r_rem;
    assign pick   = eff & (~eff + cccpg_pkg::NUM_PTS'(1));
    assign rem_n  = eff & ~pick;
    assign has_pt = (eff != '0);
    assign last   = (rem_n == '0);

    always_comb begin
        idx = '0;
        for (int i = 0; i < cccpg_pkg::NUM_PTS; i++) begin
            if (pick[i]) begin
                idx = idx | cccpg_pkg::PT_IDX_BITS'(i);
            end
        end
    end

    // Upper half of the mask belongs to the row after the diagonal move
    assign row_y = idx[cccpg_pkg::PT_IDX_BITS-1] ?
                   (i_head.y - cccpg_pkg::STEP_BITS'(1)) : i_head.y;
    assign pt    = cccpg_pkg::point_at(i_head.org_x, i_head.org_y, i_head.x, row_y, idx[2:0]);

    assign load  = i_head_valid && (!r_ovalid || i_ready);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_first  <= 1'b1;
            r_rem    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_first  <= last;
                r_rem    <= rem_n;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px     <= has_pt ? pt.px[cccpg_pkg::COORD_BITS-1:0] : '0;
            r_py     <= has_pt ? pt.py[cccpg_pkg::COORD_BITS-1:0] : '0;
            r_pvalid <= has_pt;
            r_last   <= last;
            r_done   <= i_head.done;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_valid  = r_pvalid;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

endmodule

@@ hw/rtl/clipped_circle_point_generator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_circle_point_generator_top: clipped midpoint circle generator
// Start items load a circle; step items emit the on-screen symmetric points
// of one x advance, with APB-style screen size registers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Moves
//  input     in         i_valid / o_ready    opcode, centre, radius
//  output    out        o_valid / i_ready    one point or an empty last marker
//  config    in         psel/penable/pready  screen width and height
//
//  An item is taken every cycle while the two-entry job queue has room.
//  A step yields one result per on-screen point, at least one and at most
//  16; the back end's single output register sends them one after another.
//  A start yields no result. Reset is synchronous and needs no clearing
//  pass. Output stalls back up through the queue.
// ----------------------------------------------------------------------------
module clipped_circle_point_generator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_opcode,
    input  logic [cccpg_pkg::COORD_BITS-1:0]      i_center_x,
    input  logic [cccpg_pkg::COORD_BITS-1:0]      i_center_y,
    input  logic [cccpg_pkg::RADIUS_BITS-1:0]     i_circle_radius,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [cccpg_pkg::COORD_BITS-1:0]      o_pixel_x,
    output logic [cccpg_pkg::COORD_BITS-1:0]      o_pixel_y,
    output logic                                  o_pixel_valid,
    output logic                                  o_last_of_step,
    output logic                                  o_circle_done,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cccpg_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [cccpg_pkg::DATA_BITS-1:0]       pwdata,
    output logic [cccpg_pkg::DATA_BITS-1:0]       prdata,
    output logic                                  pready
);

    logic [cccpg_pkg::COORD_BITS-1:0] r_width;
    logic [cccpg_pkg::COORD_BITS-1:0] r_height;
    logic                             cfg_wr;
    logic [cccpg_pkg::COORD_BITS-1:0] rd_val;

    logic                             queue_full;
    logic                             push;
    cccpg_pkg::t_job                  job;
    cccpg_pkg::t_job                  head;
    logic                             head_valid;
    logic                             pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cccpg_pkg::WIDTH_RST;
            r_height <= cccpg_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                cccpg_pkg::REG_SCREEN_WIDTH:  r_width  <= pwdata[cccpg_pkg::COORD_BITS-1:0];
                cccpg_pkg::REG_SCREEN_HEIGHT: r_height <= pwdata[cccpg_pkg::COORD_BITS-1:0];
                default:                      r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cccpg_pkg::REG_SCREEN_WIDTH:  rd_val = r_width;
            cccpg_pkg::REG_SCREEN_HEIGHT: rd_val = r_height;
            default:                      rd_val = '0;
        endcase
    end

    assign prdata = cccpg_pkg::DATA_BITS'(rd_val);

    cccpg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_queue_full    (queue_full),
        .i_opcode        (i_opcode),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_width         (r_width),
        .i_height        (r_height),
        .o_in_ready      (o_ready),
        .o_push          (push),
        .o_job           (job)
    );

    cccpg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (queue_full)
    );

    cccpg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .i_ready        (i_ready),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_valid  (o_pixel_valid),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

@@ hw/rtl/cccpg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cccpg_checker: port-level checks for the circle point generator
// Watches the top level's ports and flags output sequencing slips.
// ----------------------------------------------------------------------------
module cccpg_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_valid,
    input  logic                                  i_ready,
    input  logic [cccpg_pkg::COORD_BITS-1:0]      o_pixel_x,
    input  logic [cccpg_pkg::COORD_BITS-1:0]      o_pixel_y,
    input  logic                                  o_pixel_valid,
    input  logic                                  o_last_of_step,
    input  logic                                  o_circle_done,
    input  logic                                  pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
                                && $stable(o_last_of_step) && $stable(o_circle_done))
        else $error("stalled result changed");

    // An empty result always closes its step
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> o_last_of_step)
        else $error("empty result not flagged last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> (o_pixel_x == '0) && (o_pixel_y == '0))
        else $error("empty result carries coordinates");

    // Done is a property of the whole step: it cannot change mid-step
    a_done_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step ##1 o_valid |-> $stable(o_circle_done))
        else $error("done changed within a step");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind clipped_circle_point_generator_top cccpg_checker u_cccpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_pixel_valid  (o_pixel_valid),
    .o_last_of_step (o_last_of_step),
    .o_circle_done  (o_circle_done),
    .pready         (pready)
);
